// ----- rtl/hsl_pkg.sv -----
// Shared types, constants and helpers for the HTTP status line checker.
package hsl_pkg;

    // Byte values
    localparam logic [7:0] CH_CR = 8'h0D;
    localparam logic [7:0] CH_LF = 8'h0A;
    localparam logic [7:0] CH_SP = 8'h20;
    localparam logic [7:0] CH_0  = 8'h30;
    localparam logic [7:0] CH_1  = 8'h31;
    localparam logic [7:0] CH_5  = 8'h35;
    localparam logic [7:0] CH_9  = 8'h39;

    // Field positions inside the status line
    localparam logic [10:0] POS_MINOR   = 11'd7;
    localparam logic [10:0] POS_SPACE   = 11'd8;
    localparam logic [10:0] POS_DIGIT0  = 11'd9;
    localparam logic [10:0] POS_DIGIT2  = 11'd11;
    localparam logic [10:0] POS_REASON  = 11'd12;
    localparam logic [10:0] POS_MAX     = 11'd2047;

    // Code range and register reset
    localparam logic [9:0]  CODE_MIN         = 10'd100;
    localparam logic [9:0]  CODE_MAX         = 10'd599;
    localparam logic [10:0] LINE_LIMIT_RESET = 11'd512;

    // Register map (word index)
    localparam logic REG_LINE_LIMIT = 1'b0;

    // Configuration handed to the checker core
    typedef struct packed {
        logic [10:0] line_limit;
    } t_cfg;

    // Outcome of one byte
    typedef enum logic [1:0] {
        DEC_NONE = 2'd0,
        DEC_PASS = 2'd1,
        DEC_FAIL = 2'd2
    } t_decision;

    // Expected byte of the "HTTP/1." tag at positions 0 to 6
    function automatic logic [7:0] version_char(input logic [2:0] pos);
        logic [7:0] ch;
        case (pos)
            3'd0:    ch = 8'h48; // H
            3'd1:    ch = 8'h54; // T
            3'd2:    ch = 8'h54; // T
            3'd3:    ch = 8'h50; // P
            3'd4:    ch = 8'h2F; // /
            3'd5:    ch = 8'h31; // 1
            3'd6:    ch = 8'h2E; // .
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

endpackage

// ----- rtl/http_status_line_check_unit.sv -----
// Top level of the HTTP status line checker: APB registers and checker core.
//
// Checks the status line at the head of each reply buffer, one byte per word
// on the slave stream (tlast marks the buffer's final byte). One verdict word
// per buffer appears on the master stream at the byte that decides it: the
// status code 100..599 with tuser high, or code 0 with tuser low on failure.
// A byte is accepted every cycle while the verdict side takes its words; a
// verdict word held by a low tready stalls the byte input until it leaves.
// The deciding byte passes through the input register, then the per-byte
// decision and state update, and the verdict is registered in the result
// register. Register 0 (byte address 0) is line_limit, 11 bits, reset 512:
// the CR ending the line must sit below this position.
// Write it only while no buffer is in flight.
module http_status_line_check_unit
    import hsl_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // APB configuration
    input  logic        i_psel,
    input  logic        i_penable,
    input  logic        i_pwrite,
    input  logic [2:0]  i_paddr,
    input  logic [31:0] i_pwdata,
    output logic [31:0] o_prdata,
    output logic        o_pready,
    // reply bytes
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // [7:0] data_byte
    input  logic        i_s_tlast,   // last_byte
    // verdicts
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [15:0] o_m_tdata,   // [9:0] status_code, [15:10] zero
    output logic        o_m_tuser    // line_ok
);

    t_cfg       w_cfg;
    logic [9:0] w_code;

    hsl_cfg u_cfg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_psel    (i_psel),
        .i_penable (i_penable),
        .i_pwrite  (i_pwrite),
        .i_paddr   (i_paddr),
        .i_pwdata  (i_pwdata),
        .o_prdata  (o_prdata),
        .o_pready  (o_pready),
        .o_cfg     (w_cfg)
    );

    hsl_core u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (w_cfg),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_byte   (i_s_tdata),
        .i_s_last   (i_s_tlast),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_code   (w_code),
        .o_m_ok     (o_m_tuser)
    );

    assign o_m_tdata = {6'd0, w_code};

endmodule

// ----- rtl/hsl_cfg.sv -----
// APB register block holding the line limit of the status line checker.
module hsl_cfg
    import hsl_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_psel,
    input  logic        i_penable,
    input  logic        i_pwrite,
    input  logic [2:0]  i_paddr,
    input  logic [31:0] i_pwdata,
    output logic [31:0] o_prdata,
    output logic        o_pready,
    output t_cfg        o_cfg
);

    logic [10:0] r_line_limit;
    logic [10:0] n_line_limit;
    logic        w_wr;

    assign o_pready = 1'b1;
    assign w_wr     = i_psel && i_penable && i_pwrite;

    // Register write decode
    always_comb begin
        n_line_limit = r_line_limit;
        if (w_wr && (i_paddr[2] == REG_LINE_LIMIT)) begin
            n_line_limit = i_pwdata[10:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_limit <= LINE_LIMIT_RESET;
        end else begin
            r_line_limit <= n_line_limit;
        end
    end

    // Read back
    always_comb begin
        if (i_paddr[2] == REG_LINE_LIMIT) begin
            o_prdata = {21'd0, r_line_limit};
        end else begin
            o_prdata = 32'd0;
        end
    end

    assign o_cfg.line_limit = r_line_limit;

endmodule

// ----- rtl/hsl_core.sv -----
// Byte-wise status line check: input register, running state, result register.
module hsl_core
    import hsl_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cfg       i_cfg,
    input  logic       i_s_tvalid,
    output logic       o_s_tready,
    input  logic [7:0] i_s_byte,
    input  logic       i_s_last,
    output logic       o_m_tvalid,
    input  logic       i_m_tready,
    output logic [9:0] o_m_code,
    output logic       o_m_ok
);

    // Input register
    logic       r_in_valid, n_in_valid;
    logic [7:0] r_in_byte,  n_in_byte;
    logic       r_in_last,  n_in_last;

    // Per-buffer state
    logic [10:0] r_pos,     n_pos;
    logic [9:0]  r_accum,   n_accum;
    logic        r_cr,      n_cr;
    logic        r_verdict, n_verdict;

    // Result register
    logic       r_out_valid, n_out_valid;
    logic [9:0] r_out_code,  n_out_code;
    logic       r_out_ok,    n_out_ok;

    logic        w_consume;
    logic [3:0]  w_digit;
    logic [13:0] w_accum_next;
    logic        w_is_digit;
    t_decision   w_dec;

    // A byte leaves the input register when the result slot is free or draining
    assign w_consume  = r_in_valid && (!r_out_valid || i_m_tready);
    assign o_s_tready = !r_in_valid || w_consume;

    assign w_digit      = 4'(r_in_byte - CH_0);
    assign w_is_digit   = (r_in_byte >= CH_0) && (r_in_byte <= CH_9);
    assign w_accum_next = {4'd0, r_accum} * 14'd10 + {10'd0, w_digit};

    // Input register load
    always_comb begin
        n_in_valid = r_in_valid;
        n_in_byte  = r_in_byte;
        n_in_last  = r_in_last;
        if (o_s_tready) begin
            n_in_valid = i_s_tvalid;
            n_in_byte  = i_s_byte;
            n_in_last  = i_s_last;
        end
    end

    // Decision for the byte at the current position
    always_comb begin
        w_dec   = DEC_NONE;
        n_accum = r_accum;
        n_cr    = r_cr;
        if (r_pos < POS_MINOR) begin
            if (r_in_byte != version_char(r_pos[2:0])) w_dec = DEC_FAIL;
        end else if (r_pos == POS_MINOR) begin
            if (r_in_byte != CH_0 && r_in_byte != CH_1) w_dec = DEC_FAIL;
        end else if (r_pos == POS_SPACE) begin
            if (r_in_byte != CH_SP) w_dec = DEC_FAIL;
        end else if (r_pos <= POS_DIGIT2) begin
            // leading digit must be 1..5 to stay in range
            if (!w_is_digit ||
                (r_pos == POS_DIGIT0 && (r_in_byte < CH_1 || r_in_byte > CH_5))) begin
                w_dec = DEC_FAIL;
            end else begin
                n_accum = w_accum_next[9:0];
            end
        end else if (r_cr) begin
            w_dec = (r_in_byte == CH_LF) ? DEC_PASS : DEC_FAIL;
        end else begin
            if (r_pos == POS_REASON && r_in_byte != CH_SP && r_in_byte != CH_CR) begin
                w_dec = DEC_FAIL;
            end else if (r_pos >= i_cfg.line_limit || r_in_byte == CH_LF) begin
                w_dec = DEC_FAIL;
            end else if (r_in_byte == CH_CR) begin
                n_cr = 1'b1;
            end
        end
        // buffer ended before anything decided
        if (w_dec == DEC_NONE && r_in_last) w_dec = DEC_FAIL;
    end

    // State and result update
    always_comb begin
        n_pos       = r_pos;
        n_verdict   = r_verdict;
        n_out_valid = r_out_valid && !i_m_tready;
        n_out_code  = r_out_code;
        n_out_ok    = r_out_ok;
        if (w_consume) begin
            if (!r_verdict && w_dec != DEC_NONE) begin
                n_verdict   = 1'b1;
                n_out_valid = 1'b1;
                if (w_dec == DEC_PASS && r_accum >= CODE_MIN && r_accum <= CODE_MAX) begin
                    n_out_code = r_accum;
                    n_out_ok   = 1'b1;
                end else begin
                    n_out_code = 10'd0;
                    n_out_ok   = 1'b0;
                end
            end
            if (r_pos != POS_MAX) n_pos = r_pos + 11'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_pos       <= 11'd0;
            r_accum     <= 10'd0;
            r_cr        <= 1'b0;
            r_verdict   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
            if (w_consume && r_in_last) begin
                // end of buffer: start over for the next one
                r_pos     <= 11'd0;
                r_accum   <= 10'd0;
                r_cr      <= 1'b0;
                r_verdict <= 1'b0;
            end else if (w_consume && !r_verdict) begin
                r_pos     <= n_pos;
                r_accum   <= n_accum;
                r_cr      <= n_cr;
                r_verdict <= n_verdict;
            end else begin
                r_pos     <= n_pos;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_in_byte  <= n_in_byte;
        r_in_last  <= n_in_last;
        r_out_code <= n_out_code;
        r_out_ok   <= n_out_ok;
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_code   = r_out_code;
    assign o_m_ok     = r_out_ok;

    // Checks
    a_ok_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_ok |-> r_out_code >= CODE_MIN && r_out_code <= CODE_MAX)
        else $error("passing word carries a code out of range");

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_out_ok |-> r_out_code == 10'd0)
        else $error("failing word carries a nonzero code");

    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_consume && r_in_last |=> r_pos == 11'd0 && !r_verdict && !r_cr)
        else $error("buffer state not cleared after final byte");

    a_cr_position: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cr |-> r_pos > POS_REASON)
        else $error("pending CR before the reason field");

    a_one_verdict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_consume && r_verdict |=> !(r_out_valid && !$past(r_out_valid && !i_m_tready)))
        else $error("second verdict for one buffer");

endmodule
